// ----- hdl/pcs_pkg.sv -----
// Shared types, sizes and codes of the priority counting semaphore.
package pcs_pkg;

	localparam int WAIT_SLOTS = 16;
	localparam int PRIO_BITS  = 8;
	localparam int COUNT_BITS = 8;

	localparam int SLOT_W = $clog2(WAIT_SLOTS);
	localparam int RANK_W = SLOT_W;
	localparam int CNT_W  = $clog2(WAIT_SLOTS + 1);

	localparam logic [1:0] OP_OBTAIN  = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CANCEL  = 2'd2;

	localparam logic [3:0] STAT_GRANTED     = 4'd0;
	localparam logic [3:0] STAT_REFUSED     = 4'd1;
	localparam logic [3:0] STAT_QUEUED      = 4'd2;
	localparam logic [3:0] STAT_HANDED      = 4'd3;
	localparam logic [3:0] STAT_RAISED      = 4'd4;
	localparam logic [3:0] STAT_CANCELLED   = 4'd5;
	localparam logic [3:0] STAT_OVERFLOW    = 4'd6;
	localparam logic [3:0] STAT_FULL_DUP    = 4'd7;
	localparam logic [3:0] STAT_NOT_WAITING = 4'd8;

	typedef struct packed {
		logic [3:0]           task_id;
		logic [PRIO_BITS-1:0] prio;
		logic [RANK_W-1:0]    rank;
	} slot_t;

	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              we;
		logic [SLOT_W-1:0] wr_addr;
		slot_t             wr_data;
	} ram_req_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] task_id;
		logic [7:0] task_prio;
		logic       may_wait;
	} cmd_t;

	typedef struct packed {
		logic [3:0] status;
		logic [3:0] granted_task;
		logic [7:0] units_left;
		logic [4:0] waiters_now;
	} res_t;

endpackage

// ----- hdl/pcs_if.sv -----
// Valid/ready channel interfaces for semaphore commands and results.
interface pcs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [3:0] task_id;
	logic [7:0] task_prio;
	logic       may_wait;

	modport source(output valid, output op, output task_id, output task_prio,
		output may_wait, input ready);
	modport sink(input valid, input op, input task_id, input task_prio,
		input may_wait, output ready);
endinterface

interface pcs_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [3:0] granted_task;
	logic [7:0] units_left;
	logic [4:0] waiters_now;

	modport source(output valid, output status, output granted_task,
		output units_left, output waiters_now, input ready);
	modport sink(input valid, input status, input granted_task,
		input units_left, input waiters_now, output ready);
endinterface

// ----- hdl/pcs_slot_ram.sv -----
// Waiter slot memory: one write port, one registered read port.
module pcs_slot_ram (
	input  logic             clk,
	input  pcs_pkg::ram_req_t req,
	output pcs_pkg::slot_t   rd_data
);
	import pcs_pkg::*;

	slot_t mem [WAIT_SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ----- hdl/pcs_ctrl.sv -----
// Sequencer: decides each item, scans the slot memory and renumbers ranks.
module pcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  pcs_pkg::cmd_t     cmd,
	output logic              res_valid,
	output pcs_pkg::res_t     res,
	input  logic              res_take,
	output pcs_pkg::ram_req_t ram_req,
	input  pcs_pkg::slot_t    ram_rd
);
	import pcs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DROP = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	localparam logic [CNT_W-1:0] PTR_END = CNT_W'(WAIT_SLOTS);

	logic [1:0]            state_q;
	logic [WAIT_SLOTS-1:0] valid_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] max_q;
	logic [CNT_W-1:0]      arr_cnt_q;
	logic [CNT_W-1:0]      ptr_q;
	logic                  pend_s1;
	logic [SLOT_W-1:0]     idx_s1;
	logic [1:0]            op_q;
	logic [3:0]            task_q;
	logic [PRIO_BITS-1:0]  prio_q;
	logic [RANK_W-1:0]     rank_q;
	logic [3:0]            status_q;
	logic [3:0]            granted_q;

	logic                  hit_q;
	logic [SLOT_W-1:0]     hit_idx_q;
	logic [RANK_W-1:0]     best_rank_q;
	logic [PRIO_BITS-1:0]  best_prio_q;
	logic [3:0]            best_task_q;

	logic                  hit_n;
	logic [SLOT_W-1:0]     idx_n;
	logic [RANK_W-1:0]     rank_n;
	logic [PRIO_BITS-1:0]  prio_n;
	logic [3:0]            task_n;
	logic                  better;
	logic                  rd_en;
	logic                  scan_end;
	logic [SLOT_W-1:0]     free_idx;
	logic                  all_full;
	logic                  none_waiting;

	assign cmd_ready    = (state_q == S_IDLE);
	assign rd_en        = ((state_q == S_SCAN) || (state_q == S_DROP)) && (ptr_q != PTR_END);
	assign scan_end     = pend_s1 && (ptr_q == PTR_END);
	assign all_full     = &valid_q;
	assign none_waiting = ~|valid_q;

	// Lowest-numbered free slot.
	always_comb begin
		free_idx = '0;
		for (int i = WAIT_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end

	// Running match during a scan: best waiter for release, task hit otherwise.
	always_comb begin
		hit_n  = hit_q;
		idx_n  = hit_idx_q;
		rank_n = best_rank_q;
		prio_n = best_prio_q;
		task_n = best_task_q;
		better = 1'b0;
		if ((state_q == S_SCAN) && pend_s1 && valid_q[idx_s1]) begin
			if (op_q == OP_RELEASE) begin
				better = !hit_q || (ram_rd.prio < best_prio_q) ||
					((ram_rd.prio == best_prio_q) && (ram_rd.rank < best_rank_q));
			end else begin
				better = !hit_q && (ram_rd.task_id == task_q);
			end
		end
		if (better) begin
			hit_n  = 1'b1;
			idx_n  = idx_s1;
			rank_n = ram_rd.rank;
			prio_n = ram_rd.prio;
			task_n = ram_rd.task_id;
		end
	end

	always_comb begin
		ram_req.rd_en   = rd_en;
		ram_req.rd_addr = ptr_q[SLOT_W-1:0];
		ram_req.we      = 1'b0;
		ram_req.wr_addr = free_idx;
		ram_req.wr_data = '{task_id: task_q, prio: prio_q, rank: arr_cnt_q[RANK_W-1:0]};
		if ((state_q == S_SCAN) && scan_end && (op_q == OP_OBTAIN) && !hit_n) begin
			ram_req.we = 1'b1;
		end
		if ((state_q == S_DROP) && pend_s1 && valid_q[idx_s1] && (ram_rd.rank > rank_q)) begin
			ram_req.we           = 1'b1;
			ram_req.wr_addr      = idx_s1;
			ram_req.wr_data      = ram_rd;
			ram_req.wr_data.rank = ram_rd.rank - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[SLOT_W-1:0];
		if (state_q == S_IDLE) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_n;
		end
		hit_idx_q   <= idx_n;
		best_rank_q <= rank_n;
		best_prio_q <= prio_n;
		best_task_q <= task_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			count_q   <= COUNT_BITS'(1);
			max_q     <= COUNT_BITS'(1);
			arr_cnt_q <= '0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			op_q      <= OP_OBTAIN;
			task_q    <= '0;
			prio_q    <= '0;
			rank_q    <= '0;
			status_q  <= STAT_REFUSED;
			granted_q <= '0;
		end else begin
			pend_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					if (cmd_valid) begin
						op_q      <= cmd.op;
						task_q    <= cmd.task_id;
						prio_q    <= PRIO_BITS'(cmd.task_prio);
						granted_q <= '0;
						state_q   <= S_DONE;
						case (cmd.op)
							OP_OBTAIN: begin
								if (count_q != '0) begin
									count_q   <= count_q - 1'b1;
									status_q  <= STAT_GRANTED;
									granted_q <= cmd.task_id;
								end else if (!cmd.may_wait) begin
									status_q <= STAT_REFUSED;
								end else if (all_full) begin
									status_q <= STAT_FULL_DUP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_RELEASE: begin
								if (!none_waiting) begin
									state_q <= S_SCAN;
								end else if (count_q >= max_q) begin
									status_q <= STAT_OVERFLOW;
								end else begin
									count_q  <= count_q + 1'b1;
									status_q <= STAT_RAISED;
								end
							end
							OP_CANCEL: begin
								if (none_waiting) begin
									status_q <= STAT_NOT_WAITING;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								status_q <= STAT_REFUSED;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (scan_end) begin
						ptr_q <= '0;
						case (op_q)
							OP_OBTAIN: begin
								state_q <= S_DONE;
								if (hit_n) begin
									status_q <= STAT_FULL_DUP;
								end else begin
									valid_q[free_idx] <= 1'b1;
									arr_cnt_q         <= arr_cnt_q + 1'b1;
									status_q          <= STAT_QUEUED;
								end
							end
							OP_RELEASE: begin
								valid_q[idx_n] <= 1'b0;
								rank_q         <= rank_n;
								arr_cnt_q      <= arr_cnt_q - 1'b1;
								granted_q      <= task_n;
								status_q       <= STAT_HANDED;
								state_q        <= S_DROP;
							end
							default: begin
								if (hit_n) begin
									valid_q[idx_n] <= 1'b0;
									rank_q         <= rank_n;
									arr_cnt_q      <= arr_cnt_q - 1'b1;
									status_q       <= STAT_CANCELLED;
									state_q        <= S_DROP;
								end else begin
									status_q <= STAT_NOT_WAITING;
									state_q  <= S_DONE;
								end
							end
						endcase
					end
				end
				S_DROP: begin
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (scan_end) begin
						ptr_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				max_q   <= COUNT_BITS'(cfg_wdata);
				count_q <= COUNT_BITS'(cfg_wdata);
			end
		end
	end

	assign res_valid        = (state_q == S_DONE);
	assign res.status       = status_q;
	assign res.granted_task = granted_q;
	assign res.units_left   = 8'(count_q);
	assign res.waiters_now  = 5'(arr_cnt_q);

endmodule

// ----- hdl/priority_counting_semaphore.sv -----
// Top level of the priority counting semaphore: sequencer, slot memory, result register.
//
// A counting semaphore with a table of up to sixteen waiting tasks. An obtain
// takes a unit while the count is nonzero; otherwise the task is queued with
// its priority, refused when it may not wait, or turned away as full or
// duplicate when the table is full or the task already waits. A release
// hands its unit straight to the waiter with the lowest priority number
// (oldest first on a tie); with nobody waiting it raises the count, or
// reports overflow at max_count. A cancel removes a waiting task. Every
// item yields exactly one result item. Writing cfg_wdata with cfg_we reloads
// both max_count and the count; waiters are kept. Items decided from the
// count alone are only accepted and presented. Other items are bound by the
// single read port of the slot memory: one pass over every slot to find
// the match, and for a removal a second read-modify-write pass that moves
// every younger waiter up one rank. One item is in work at a time; the
// result register lets the next item be accepted while a result still
// waits to be taken.
module priority_counting_semaphore (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	pcs_cmd_if.sink    cmd,
	pcs_rsp_if.source  rsp
);
	import pcs_pkg::*;

	cmd_t     cmd_data;
	res_t     res_data;
	res_t     rsp_q;
	logic     rsp_valid_q;
	logic     res_valid;
	logic     res_take;
	ram_req_t ram_req;
	slot_t    ram_rd;

	// Pack the command channel into one word for the sequencer.
	assign cmd_data.op        = cmd.op;
	assign cmd_data.task_id   = cmd.task_id;
	assign cmd_data.task_prio = cmd.task_prio;
	assign cmd_data.may_wait  = cmd.may_wait;

	pcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd       (cmd_data),
		.res_valid (res_valid),
		.res       (res_data),
		.res_take  (res_take),
		.ram_req   (ram_req),
		.ram_rd    (ram_rd)
	);

	pcs_slot_ram u_slot_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (ram_rd)
	);

	// Move a finished result into the output register when it is empty or
	// being drained this cycle.
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload until taken.
	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res_data;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.granted_task = rsp_q.granted_task;
	assign rsp.units_left   = rsp_q.units_left;
	assign rsp.waiters_now  = rsp_q.waiters_now;

endmodule
